FILE: src/bae_pkg.sv
package bae_pkg;

  localparam int REG_WIDTH = 64;
  localparam int IN_W = 88;
  localparam int OUT_W = 232;
  localparam int N_GPR = 6;

  typedef struct packed {
    logic start;
    logic is_signed;
  } unit_ctl_t;

endpackage

FILE: src/bae_mul.sv
module bae_mul #(
  parameter int W = bae_pkg::REG_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [W-1:0]     a,
  input  logic [W-1:0]     b,
  output logic             done,
  output logic [W-1:0]     lo,
  output logic [W-1:0]     hi
);
  import bae_pkg::*;

  localparam int H = W / 2;

  logic [2:0]     cnt;
  logic           busy;
  logic [W-1:0]   prod;
  logic [1:0]     pshift;
  logic [2*W-1:0] acc;
  logic [2*W-1:0] term;
  logic [H-1:0]   ah;
  logic [H-1:0]   bh;

  assign ah = cnt[1] ? a[W-1:H] : a[H-1:0];
  assign bh = cnt[0] ? b[W-1:H] : b[H-1:0];

  always_comb begin
    case (pshift)
      2'd0: term = {{W{1'b0}}, prod};
      2'd1: term = {{H{1'b0}}, prod, {H{1'b0}}};
      2'd2: term = {prod, {W{1'b0}}};
      default: term = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt <= '0;
      acc <= '0;
      pshift <= 2'd3;
    end else if (busy) begin
      if (cnt != 3'd4) begin
        prod <= W'(ah) * W'(bh);
        pshift <= 2'(cnt[1]) + 2'(cnt[0]);
      end
      if (pshift != 2'd3) acc <= acc + term;
      if (cnt == 3'd4) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
      cnt <= cnt + 3'd1;
    end
  end

  assign lo = acc[W-1:0];
  assign hi = acc[2*W-1:W];

endmodule

FILE: src/bae_div.sv
module bae_div #(
  parameter int W = bae_pkg::REG_WIDTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] n,
  input  logic [W-1:0] d,
  output logic         done,
  output logic [W-1:0] q,
  output logic [W-1:0] r
);
  import bae_pkg::*;

  localparam int CW = $clog2(W + 1);

  logic [CW-1:0] cnt;
  logic          busy;
  logic [W-1:0]  dv;
  logic [W:0]    sh;
  logic          ge;

  assign sh = {r, q[W-1]};
  assign ge = sh >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt <= '0;
      q <= n;
      r <= '0;
      dv <= d;
    end else if (busy) begin
      r <= ge ? W'(sh - {1'b0, dv}) : sh[W-1:0];
      q <= {q[W-2:0], ge};
      cnt <= cnt + CW'(1);
      if (cnt == CW'(W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

FILE: src/bytecode_alu_execute_unit.sv
// Each word passes through the states ST_IDLE (accept), ST_ISSUE, ST_WAIT and ST_OUT (result);
// multiplies form four 32x32 partial products through one multiplier,
// and divide and remainder produce one quotient bit per cycle.
// One word in flight; s_tready is low until the result word is taken.
// rst (synchronous) clears the general registers, compare flag and pointers.
module bytecode_alu_execute_unit #(
  parameter int REG_WIDTH = bae_pkg::REG_WIDTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // opcode, dest_index, dest2_index, x_from_reg, x_reg, x_imm, y_from_reg, y_reg, y_imm
  input  logic [bae_pkg::IN_W-1:0]  s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // r_written, r_value, w_written, w_value, compare_flag, branch_taken,
  // branch_offset, exit_taken, exit_value, bad_dest
  output logic [bae_pkg::OUT_W-1:0] m_tdata,
  input  logic                      cfg_we,
  input  logic [0:0]                cfg_index,
  input  logic [REG_WIDTH-1:0]      cfg_data
);
  import bae_pkg::*;

  localparam int W = REG_WIDTH;
  localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

  localparam logic [5:0] OP_ADD = 6'd0, OP_SUB = 6'd1, OP_MUL = 6'd2, OP_DIVU = 6'd3,
    OP_REMU = 6'd4, OP_DIVS = 6'd5, OP_REMS = 6'd6, OP_AND = 6'd7, OP_OR = 6'd8,
    OP_XOR = 6'd9, OP_ANDC = 6'd10, OP_ORC = 6'd11, OP_XORC = 6'd12, OP_NAND = 6'd13,
    OP_NOR = 6'd14, OP_SHL = 6'd15, OP_SHR32 = 6'd16, OP_SAR32 = 6'd17,
    OP_ROL32 = 6'd18, OP_ROR32 = 6'd19, OP_MOVC = 6'd20, OP_SHR64 = 6'd21,
    OP_SAR64 = 6'd22, OP_ROL64 = 6'd23, OP_ROR64 = 6'd24, OP_CONCAT = 6'd25,
    OP_EXTR = 6'd26, OP_SEXTR = 6'd27, OP_CTZ = 6'd28, OP_CLZ = 6'd29,
    OP_CMP32 = 6'd30, OP_CMP64 = 6'd40, OP_CMPEND = 6'd49, OP_BSW16 = 6'd50,
    OP_BSW32 = 6'd51, OP_BSW64 = 6'd52, OP_POP = 6'd53, OP_SETC = 6'd54,
    OP_DEP = 6'd55, OP_BRC = 6'd56, OP_BR = 6'd57, OP_EXIT = 6'd58,
    OP_MULU2 = 6'd59, OP_MULS2 = 6'd60, OP_ADD2 = 6'd61, OP_SUB2 = 6'd62;

  localparam logic [3:0] CMP_EQ = 4'd0, CMP_NE = 4'd1, CMP_LT = 4'd2, CMP_LE = 4'd3,
    CMP_GT = 4'd4, CMP_GE = 4'd5, CMP_LTU = 4'd6, CMP_LEU = 4'd7, CMP_GTU = 4'd8;

  typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_OUT} state_t;

  function automatic logic do_cmp(input logic [3:0] k, input logic [W-1:0] a,
                                  input logic [W-1:0] b);
    logic slt, sgt;
    slt = $signed(a) < $signed(b);
    sgt = $signed(a) > $signed(b);
    case (k)
      CMP_EQ:  do_cmp = a == b;
      CMP_NE:  do_cmp = a != b;
      CMP_LT:  do_cmp = slt;
      CMP_LE:  do_cmp = !sgt;
      CMP_GT:  do_cmp = sgt;
      CMP_GE:  do_cmp = !slt;
      CMP_LTU: do_cmp = a < b;
      CMP_LEU: do_cmp = a <= b;
      CMP_GTU: do_cmp = a > b;
      default: do_cmp = a >= b;
    endcase
  endfunction

  // input fields
  logic [5:0]  in_op;
  logic [2:0]  in_ri, in_wi, in_xreg, in_yreg;
  logic        in_xfr, in_yfr;
  logic [31:0] in_ximm, in_yimm;

  assign in_op   = s_tdata[5:0];
  assign in_ri   = s_tdata[8:6];
  assign in_wi   = s_tdata[11:9];
  assign in_xfr  = s_tdata[12];
  assign in_xreg = s_tdata[15:13];
  assign in_ximm = s_tdata[47:16];
  assign in_yfr  = s_tdata[48];
  assign in_yreg = s_tdata[51:49];
  assign in_yimm = s_tdata[83:52];

  state_t       state;
  logic [W-1:0] gpr [N_GPR];
  logic [W-1:0] env_pointer, frame_pointer;
  logic         cmp_flag;

  logic [5:0]   op;
  logic [2:0]   ri, wi;
  logic [W-1:0] x, y, wb, rb;

  function automatic logic [W-1:0] rd(input logic [2:0] i, input logic [W-1:0] e,
                                      input logic [W-1:0] f, input logic [W-1:0] g0,
                                      input logic [W-1:0] g1, input logic [W-1:0] g2,
                                      input logic [W-1:0] g3, input logic [W-1:0] g4,
                                      input logic [W-1:0] g5);
    case (i)
      3'd0: rd = g0;
      3'd1: rd = g1;
      3'd2: rd = g2;
      3'd3: rd = g3;
      3'd4: rd = g4;
      3'd5: rd = g5;
      3'd6: rd = e;
      default: rd = f;
    endcase
  endfunction

  // shared units
  logic         is_mul, is_div, sgn_div;
  logic         nx, ny;
  logic [W-1:0] ux, uy;
  unit_ctl_t    mul_ctl, div_ctl;
  logic         mul_done, div_done;
  logic [W-1:0] mlo, mhi, dq, dr;

  assign is_mul  = op == OP_MUL || op == OP_MULU2 || op == OP_MULS2;
  assign is_div  = op == OP_DIVU || op == OP_REMU || op == OP_DIVS || op == OP_REMS;
  assign sgn_div = op == OP_DIVS || op == OP_REMS;
  assign nx = x[W-1];
  assign ny = y[W-1];
  assign ux = nx ? -x : x;
  assign uy = ny ? -y : y;

  assign mul_ctl = '{start: state == ST_ISSUE && is_mul, is_signed: 1'b0};
  assign div_ctl = '{start: state == ST_ISSUE && is_div, is_signed: sgn_div};

  bae_mul #(.W(W)) u_mul (
    .clk(clk), .rst(rst), .start(mul_ctl.start), .a(x), .b(y),
    .done(mul_done), .lo(mlo), .hi(mhi)
  );

  bae_div #(.W(W)) u_div (
    .clk(clk), .rst(rst), .start(div_ctl.start),
    .n(div_ctl.is_signed ? ux : x), .d(div_ctl.is_signed ? uy : y),
    .done(div_done), .q(dq), .r(dr)
  );

  // result logic
  logic [5:0]     pos, len, sh6;
  logic [4:0]     sh5;
  logic [W-1:0]   fmask, ext, dmask, x32s, cnt_z;
  logic [2*W-1:0] rot64;
  logic [63:0]    rot32;
  logic [W-1:0]   r, w;
  logic           want_r, want_w, br, ex, flag_n, carry;
  logic [6:0]     tz, lz;

  assign pos   = y[11:6];
  assign len   = y[5:0];
  assign fmask = (W'(1) << len) - W'(1);
  assign ext   = (x >> pos) & fmask;
  assign dmask = fmask << pos;
  assign x32s  = {{(W-32){x[31]}}, x[31:0]};
  assign sh5   = (op == OP_ROR32) ? -y[4:0] : y[4:0];
  assign sh6   = (op == OP_ROR64) ? -y[5:0] : y[5:0];
  assign rot32 = {x[31:0], x[31:0]} << sh5;
  assign rot64 = {x, x} << sh6;

  always_comb begin
    tz = 7'd0;
    lz = 7'd0;
    for (int i = W - 1; i >= 0; i--) if (x[i]) tz = 7'(i);
    for (int i = 0; i < W; i++) if (x[i]) lz = 7'(W - 1 - i);
  end

  always_comb begin
    r = '0;
    w = wb;
    want_r = 1'b1;
    want_w = 1'b0;
    br = 1'b0;
    ex = 1'b0;
    flag_n = cmp_flag;
    carry = 1'b0;
    cnt_z = '0;
    case (op)
      OP_ADD:   r = x + y;
      OP_SUB:   r = x - y;
      OP_MUL:   r = mlo;
      OP_DIVU:  r = (y == '0) ? '1 : dq;
      OP_REMU:  r = (y == '0) ? x : dr;
      OP_DIVS: begin
        if (y == '0) r = '1;
        else if (x == SMIN && y == '1) r = ~SMIN;
        else r = (nx != ny) ? -dq : dq;
      end
      OP_REMS: begin
        if (y == '0) r = x;
        else if (x == SMIN && y == '1) r = '0;
        else r = nx ? -dr : dr;
      end
      OP_AND:    r = x & y;
      OP_OR:     r = x | y;
      OP_XOR:    r = x ^ y;
      OP_ANDC:   r = x & ~y;
      OP_ORC:    r = x | ~y;
      OP_XORC:   r = x ^ ~y;
      OP_NAND:   r = ~(x & y);
      OP_NOR:    r = ~(x | y);
      OP_SHL:    r = x << y[5:0];
      OP_SHR32:  r = {{(W-32){1'b0}}, x[31:0]} >> y[4:0];
      OP_SAR32:  r = W'($signed(x32s) >>> y[4:0]);
      OP_ROL32, OP_ROR32: r = {{(W-32){1'b0}}, rot32[63:32]};
      OP_MOVC:   r = cmp_flag ? x : y;
      OP_SHR64:  r = x >> y[5:0];
      OP_SAR64:  r = W'($signed(x) >>> y[5:0]);
      OP_ROL64, OP_ROR64: r = rot64[2*W-1:W];
      OP_CONCAT: r = {x[31:0], y[31:0]};
      OP_EXTR:   r = ext;
      OP_SEXTR:  r = (len != 6'd0 && ext[len - 6'd1]) ? (ext | ~fmask) : ext;
      OP_CTZ: begin
        cnt_z = W'(tz);
        r = (x == '0) ? y : cnt_z;
      end
      OP_CLZ: begin
        cnt_z = W'(lz);
        r = (x == '0) ? y : cnt_z;
      end
      OP_BSW16:  r = {{(W-16){1'b0}}, y[7:0], y[15:8]};
      OP_BSW32:  r = {{(W-32){1'b0}}, y[7:0], y[15:8], y[23:16], y[31:24]};
      OP_BSW64:  r = {<<8{y}};
      OP_POP:    r = W'($countones(y));
      OP_SETC:   r = W'(cmp_flag);
      OP_DEP:    r = (wb & ~dmask) | ((x << pos) & dmask);
      OP_BRC: begin
        want_r = 1'b0;
        br = cmp_flag;
      end
      OP_BR: begin
        want_r = 1'b0;
        br = 1'b1;
      end
      OP_EXIT: begin
        want_r = 1'b0;
        ex = 1'b1;
      end
      OP_MULU2: begin
        r = mlo;
        w = mhi;
        want_w = 1'b1;
      end
      OP_MULS2: begin
        r = mlo;
        w = mhi - (nx ? y : '0) - (ny ? x : '0);
        want_w = 1'b1;
      end
      OP_ADD2: begin
        r = rb + y;
        carry = r < y;
        w = wb + x + W'(carry);
        want_w = 1'b1;
      end
      OP_SUB2: begin
        carry = rb < y;
        w = wb - x - W'(carry);
        r = rb - y;
        want_w = 1'b1;
      end
      default: begin
        want_r = 1'b0;
        if (op >= OP_CMP32 && op < OP_CMP64)
          flag_n = do_cmp(4'(op - OP_CMP32), x32s,
                          {{(W-32){y[31]}}, y[31:0]});
        else if (op >= OP_CMP64 && op <= OP_CMPEND)
          flag_n = do_cmp(4'(op - OP_CMP64), x, y);
      end
    endcase
  end

  logic rw, ww, bad;
  assign ww  = want_w && wi < 3'd6;
  assign rw  = want_r && ri < 3'd6;
  assign bad = (want_w && wi >= 3'd6) || (want_r && ri >= 3'd6);

  logic         o_rw, o_ww, o_flag, o_br, o_ex, o_bad;
  logic [W-1:0] o_r, o_w, o_exv;
  logic [31:0]  o_off;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cmp_flag <= 1'b0;
      env_pointer <= '0;
      frame_pointer <= '0;
      for (int i = 0; i < N_GPR; i++) gpr[i] <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == 1'b0) env_pointer <= cfg_data;
        else frame_pointer <= cfg_data;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            op <= in_op;
            ri <= in_ri;
            wi <= in_wi;
            x  <= in_xfr ? rd(in_xreg, env_pointer, frame_pointer, gpr[0], gpr[1],
                              gpr[2], gpr[3], gpr[4], gpr[5])
                         : {{(W-32){in_ximm[31]}}, in_ximm};
            y  <= in_yfr ? rd(in_yreg, env_pointer, frame_pointer, gpr[0], gpr[1],
                              gpr[2], gpr[3], gpr[4], gpr[5])
                         : {{(W-32){in_yimm[31]}}, in_yimm};
            wb <= rd(in_wi, env_pointer, frame_pointer, gpr[0], gpr[1], gpr[2],
                     gpr[3], gpr[4], gpr[5]);
            rb <= rd(in_ri, env_pointer, frame_pointer, gpr[0], gpr[1], gpr[2],
                     gpr[3], gpr[4], gpr[5]);
            state <= ST_ISSUE;
          end
        end
        ST_ISSUE: state <= ST_WAIT;
        ST_WAIT: begin
          if (!((is_mul && !mul_done) || (is_div && !div_done))) begin
            // primary value wins when both writes hit one register
            if (ww && !(rw && ri == wi)) gpr[wi] <= w;
            if (rw) gpr[ri] <= r;
            cmp_flag <= flag_n;
            o_rw <= rw;
            o_r <= rw ? r : '0;
            o_ww <= ww;
            o_w <= ww ? w : '0;
            o_flag <= flag_n;
            o_br <= br;
            o_off <= br ? y[31:0] : '0;
            o_ex <= ex;
            o_exv <= ex ? {x[31:0], y[31:0]} : '0;
            o_bad <= bad;
            state <= ST_OUT;
          end
        end
        ST_OUT: if (m_tready) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign s_tready = state == ST_IDLE;
  assign m_tvalid = state == ST_OUT;
  assign m_tdata  = {2'b00, o_bad, o_exv, o_ex, o_off, o_br, o_flag, o_w, o_ww, o_r, o_rw};

endmodule

FILE: tb/bytecode_alu_execute_unit_tb.sv
module bytecode_alu_execute_unit_tb;
  import bae_pkg::*;

  typedef enum logic [5:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_DIVU, OP_REMU, OP_DIVS, OP_REMS, OP_AND,
    OP_OR, OP_XOR, OP_ANDC, OP_ORC, OP_XORC, OP_NAND, OP_NOR, OP_SHL,
    OP_SHR32, OP_SAR32, OP_ROL32, OP_ROR32, OP_MOVC, OP_SHR64, OP_SAR64, OP_ROL64,
    OP_ROR64, OP_CONCAT, OP_EXTRACT, OP_SEXTRACT, OP_CTZ, OP_CLZ,
    OP_SETEQ32, OP_SETNE32, OP_SETLT32, OP_SETLE32, OP_SETGT32, OP_SETGE32,
    OP_SETLTU32, OP_SETLEU32, OP_SETGTU32, OP_SETGEU32,
    OP_SETEQ64, OP_SETNE64, OP_SETLT64, OP_SETLE64, OP_SETGT64, OP_SETGE64,
    OP_SETLTU64, OP_SETLEU64, OP_SETGTU64, OP_SETGEU64,
    OP_BSWAP16, OP_BSWAP32, OP_BSWAP64, OP_POPCNT, OP_SETC, OP_DEPOSIT,
    OP_BRCOND, OP_BR, OP_EXIT, OP_MULU2, OP_MULS2, OP_ADD2, OP_SUB2, OP_NOP
  } opcode_e;

  localparam logic [0:0] CFG_ENV   = 1'd0;
  localparam logic [0:0] CFG_FRAME = 1'd1;
  localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [31:0] y_imm;
    logic [2:0]  y_reg;
    logic        y_from_reg;
    logic [31:0] x_imm;
    logic [2:0]  x_reg;
    logic        x_from_reg;
    logic [2:0]  dest2_index;
    logic [2:0]  dest_index;
    opcode_e     opcode;
  } insn_t;

  typedef struct packed {
    logic        bad_dest;
    logic [63:0] exit_value;
    logic        exit_taken;
    logic [31:0] branch_offset;
    logic        branch_taken;
    logic        compare_flag;
    logic [63:0] w_value;
    logic        w_written;
    logic [63:0] r_value;
    logic        r_written;
  } result_t;

  logic clk, rst;
  logic s_tvalid, s_tready, m_tvalid, m_tready;
  logic [IN_W-1:0] s_tdata;   // opcode, dest_index, dest2_index, x_from_reg, x_reg, x_imm,
                              // y_from_reg, y_reg, y_imm
  logic [OUT_W-1:0] m_tdata;  // r_written, r_value, w_written, w_value, compare_flag,
                              // branch_taken, branch_offset, exit_taken, exit_value, bad_dest
  logic cfg_we;
  logic [0:0] cfg_index;
  logic [63:0] cfg_data;

  bytecode_alu_execute_unit DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  logic [63:0] gpr [N_GPR];
  logic [63:0] env_ptr, frame_ptr;
  logic        flag;
  result_t     expected_results[$];
  int          mismatches;
  bit          hold_rx, no_idle;
  int          rx_left;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (r < 4) return $urandom_range(20, 60);
    if (r < 40) return $urandom_range(1, 4);
    return 0;
  endfunction

  function automatic logic [63:0] sx32(logic [63:0] v);
    return {{32{v[31]}}, v[31:0]};
  endfunction

  function automatic logic [63:0] reg_value(logic [2:0] i);
    if (i == 3'd6) return env_ptr;
    if (i == 3'd7) return frame_ptr;
    return gpr[i];
  endfunction

  function automatic bit cmp_op(int k, logic [63:0] a, logic [63:0] b);
    case (k)
      0: return a == b;
      1: return a != b;
      2: return $signed(a) < $signed(b);
      3: return $signed(a) <= $signed(b);
      4: return $signed(a) > $signed(b);
      5: return $signed(a) >= $signed(b);
      6: return a < b;
      7: return a <= b;
      8: return a > b;
      default: return a >= b;
    endcase
  endfunction

  function automatic logic [63:0] rotl64(logic [63:0] v, int s);
    return s == 0 ? v : (v << s) | (v >> (64 - s));
  endfunction

  function automatic logic [31:0] rotl32(logic [31:0] v, int s);
    return s == 0 ? v : (v << s) | (v >> (32 - s));
  endfunction

  // advances the shadow machine state and returns the word the block must emit
  task automatic execute_insn(input insn_t i, output result_t o);
    logic [63:0] x, y, w, r, ux, uy, fm, m;
    logic [127:0] p;
    int pos, len, n;
    bit want_r, want_w, br, ex, bad, rw, ww, nx, ny;
    x = i.x_from_reg ? reg_value(i.x_reg) : sx32({32'd0, i.x_imm});
    y = i.y_from_reg ? reg_value(i.y_reg) : sx32({32'd0, i.y_imm});
    w = reg_value(i.dest2_index);
    r = 0;
    want_r = 1; want_w = 0; br = 0; ex = 0; bad = 0; rw = 0; ww = 0;
    pos = int'(y[11:6]);
    len = int'(y[5:0]);
    fm = (64'd1 << len) - 64'd1;
    case (i.opcode)
      OP_ADD: r = x + y;
      OP_SUB: r = x - y;
      OP_MUL: r = x * y;
      OP_DIVU: r = (y != 0) ? x / y : '1;
      OP_REMU: r = (y != 0) ? x % y : x;
      OP_DIVS, OP_REMS: begin
        nx = x[63]; ny = y[63];
        ux = nx ? -x : x;
        uy = ny ? -y : y;
        if (y == 0) r = (i.opcode == OP_DIVS) ? '1 : x;
        else if (x == MIN64 && y == '1) r = (i.opcode == OP_DIVS) ? MIN64 - 1 : 0;
        else if (i.opcode == OP_DIVS) begin
          r = ux / uy;
          if (nx != ny) r = -r;
        end else begin
          r = ux % uy;
          if (nx) r = -r;
        end
      end
      OP_AND: r = x & y;
      OP_OR: r = x | y;
      OP_XOR: r = x ^ y;
      OP_ANDC: r = x & ~y;
      OP_ORC: r = x | ~y;
      OP_XORC: r = x ^ ~y;
      OP_NAND: r = ~(x & y);
      OP_NOR: r = ~(x | y);
      OP_SHL: r = x << y[5:0];
      OP_SHR32: r = {32'd0, x[31:0]} >> y[4:0];
      OP_SAR32: r = $signed(sx32(x)) >>> y[4:0];
      OP_ROL32: r = {32'd0, rotl32(x[31:0], int'(y[4:0]))};
      OP_ROR32: r = {32'd0, rotl32(x[31:0], (32 - int'(y[4:0])) & 31)};
      OP_MOVC: r = flag ? x : y;
      OP_SHR64: r = x >> y[5:0];
      OP_SAR64: r = $signed(x) >>> y[5:0];
      OP_ROL64: r = rotl64(x, int'(y[5:0]));
      OP_ROR64: r = rotl64(x, (64 - int'(y[5:0])) & 63);
      OP_CONCAT: r = {x[31:0], y[31:0]};
      OP_EXTRACT: r = (x >> pos) & fm;
      OP_SEXTRACT: begin
        r = (x >> pos) & fm;
        if (len != 0 && r[len-1]) r = r | ~fm;
      end
      OP_CTZ: begin
        n = 0;
        while (n < 64 && !x[n]) n++;
        r = (x != 0) ? 64'(n) : y;
      end
      OP_CLZ: begin
        n = 0;
        while (n < 64 && !x[63-n]) n++;
        r = (x != 0) ? 64'(n) : y;
      end
      OP_BSWAP16: r = {48'd0, y[7:0], y[15:8]};
      OP_BSWAP32: r = {32'd0, y[7:0], y[15:8], y[23:16], y[31:24]};
      OP_BSWAP64: r = {y[7:0], y[15:8], y[23:16], y[31:24],
                       y[39:32], y[47:40], y[55:48], y[63:56]};
      OP_POPCNT: r = 64'($countones(y));
      OP_SETC: r = {63'd0, flag};
      OP_DEPOSIT: begin
        m = fm << pos;
        r = (w & ~m) | ((x << pos) & m);
      end
      OP_BRCOND: begin want_r = 0; br = flag; end
      OP_BR: begin want_r = 0; br = 1; end
      OP_EXIT: begin want_r = 0; ex = 1; end
      OP_MULU2: begin
        p = {64'd0, x} * {64'd0, y};
        r = p[63:0]; w = p[127:64]; want_w = 1;
      end
      OP_MULS2: begin
        p = $signed({{64{x[63]}}, x}) * $signed({{64{y[63]}}, y});
        r = p[63:0]; w = p[127:64]; want_w = 1;
      end
      OP_ADD2: begin
        r = reg_value(i.dest_index) + y;
        w = w + x + ((r < y) ? 64'd1 : 64'd0);
        want_w = 1;
      end
      OP_SUB2: begin
        r = reg_value(i.dest_index);
        w = w - x - ((r < y) ? 64'd1 : 64'd0);
        r = r - y;
        want_w = 1;
      end
      default: begin
        want_r = 0;
        if (i.opcode >= OP_SETEQ32 && i.opcode <= OP_SETGEU32)
          flag = cmp_op(i.opcode - OP_SETEQ32, sx32(x), sx32(y));
        else if (i.opcode >= OP_SETEQ64 && i.opcode <= OP_SETGEU64)
          flag = cmp_op(i.opcode - OP_SETEQ64, x, y);
      end
    endcase
    if (want_w) begin
      if (i.dest2_index >= 6) bad = 1;
      else begin gpr[i.dest2_index] = w; ww = 1; end
    end
    if (want_r) begin
      if (i.dest_index >= 6) bad = 1;
      else begin gpr[i.dest_index] = r; rw = 1; end
    end
    o.r_written = rw;
    o.r_value = rw ? r : 0;
    o.w_written = ww;
    o.w_value = ww ? w : 0;
    o.compare_flag = flag;
    o.branch_taken = br;
    o.branch_offset = br ? y[31:0] : 0;
    o.exit_taken = ex;
    o.exit_value = ex ? {x[31:0], y[31:0]} : 0;
    o.bad_dest = bad;
  endtask

  task automatic send_word(input insn_t i);
    int g;
    result_t res;
    g = gap_len();
    if (g > 0) begin
      @(negedge clk) s_tvalid <= 0;
      repeat (g - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1;
    s_tdata <= {4'd0, i};
    do @(posedge clk); while (!s_tready);
    execute_insn(i, res);
    expected_results.push_back(res);
  endtask

  task automatic drain();
    @(negedge clk) s_tvalid <= 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [0:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk) cfg_we <= 0;
    if (idx == CFG_ENV) env_ptr = val;
    else frame_ptr = val;
  endtask

  function automatic logic [31:0] rand_imm();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '1;
      3: return $urandom_range(0, 3);
      4: return $urandom_range(0, 4095);
      default: return $urandom;
    endcase
  endfunction

  function automatic insn_t rand_insn(opcode_e op);
    insn_t i;
    i.opcode = op;
    i.dest_index = 3'($urandom_range(0, 9) < 8 ? $urandom_range(0, 5)
                                                : $urandom_range(6, 7));
    i.dest2_index = 3'($urandom_range(0, 9) < 8 ? $urandom_range(0, 5)
                                                 : $urandom_range(6, 7));
    i.x_from_reg = 1'($urandom_range(0, 1));
    i.x_reg = 3'($urandom_range(0, 7));
    i.x_imm = rand_imm();
    i.y_from_reg = 1'($urandom_range(0, 1));
    i.y_reg = 3'($urandom_range(0, 7));
    i.y_imm = rand_imm();
    return i;
  endfunction

  function automatic insn_t mk(opcode_e op, logic [2:0] d, logic [2:0] d2,
                               bit xr, logic [31:0] xv, bit yr, logic [31:0] yv);
    insn_t i;
    i = '0;
    i.opcode = op; i.dest_index = d; i.dest2_index = d2;
    i.x_from_reg = xr; i.y_from_reg = yr;
    if (xr) i.x_reg = xv[2:0]; else i.x_imm = xv;
    if (yr) i.y_reg = yv[2:0]; else i.y_imm = yv;
    return i;
  endfunction

  task automatic test_directed();
    send_word(mk(OP_SHL, 0, 0, 0, 1, 0, 63));                     // reg0 = min
    send_word(mk(OP_DIVS, 1, 0, 1, 0, 0, '1));                    // saturating overflow
    send_word(mk(OP_REMS, 2, 0, 1, 0, 0, '1));
    send_word(mk(OP_DIVU, 3, 0, 0, 32'h8000_0000, 0, 0));         // divide by zero
    send_word(mk(OP_REMU, 3, 0, 0, 32'h7fff_ffff, 0, 0));
    send_word(mk(OP_DIVS, 4, 0, 0, 32'h8000_0000, 0, 0));
    send_word(mk(OP_REMS, 4, 0, 0, '1, 0, 0));
    send_word(mk(OP_EXTRACT, 5, 0, 0, '1, 0, 32'h0000_0fc0));     // zero length
    send_word(mk(OP_DEPOSIT, 5, 5, 0, '1, 0, 32'h0000_0fff));     // field past bit 63
    send_word(mk(OP_SEXTRACT, 1, 0, 1, 0, 0, 32'h0000_0fc1));
    send_word(mk(OP_ADD, 6, 0, 0, 5, 0, 5));                      // bad destination
    send_word(mk(OP_MULU2, 7, 6, 0, '1, 0, '1));
    send_word(mk(OP_MULS2, 2, 2, 1, 0, 0, '1));                   // same destination twice
    send_word(mk(OP_MULU2, 3, 3, 0, '1, 0, '1));
    send_word(mk(OP_ADD2, 4, 4, 0, '1, 0, '1));
    send_word(mk(OP_SUB2, 5, 1, 0, 1, 0, 32'h7fff_ffff));
    send_word(mk(OP_CTZ, 1, 0, 0, 0, 0, 32'h1234));               // zero input
    send_word(mk(OP_CLZ, 1, 0, 0, 0, 0, 32'h8000_0000));
    send_word(mk(OP_SETLT64, 0, 0, 1, 0, 0, 0));
    send_word(mk(OP_BRCOND, 0, 0, 0, 0, 0, 32'h8000_0000));
    send_word(mk(OP_MOVC, 2, 0, 1, 6, 1, 7));
    send_word(mk(OP_EXIT, 0, 0, 0, 32'h8000_0000, 0, 32'h7fff_ffff));
    send_word(mk(OP_NOP, 7, 7, 1, 7, 1, 7));
    drain();
  endtask

  task automatic test_opcode_sweep();
    for (int k = 0; k < 64; k++) send_word(rand_insn(opcode_e'(k)));
    drain();
  endtask

  task automatic test_random(input int count);
    for (int k = 0; k < count; k++) begin
      if (k % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
      send_word(rand_insn(opcode_e'($urandom_range(0, 63))));
    end
    no_idle = 0;
    drain();
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_rx = 1;
        repeat (300) @(negedge clk);
        hold_rx = 0;
      end
    join_none
    for (int k = 0; k < 30; k++) send_word(rand_insn(opcode_e'($urandom_range(0, 63))));
    drain();
  endtask

  always @(negedge clk) begin
    if (rst || hold_rx) m_tready <= 0;
    else if (rx_left > 0) begin
      m_tready <= 0;
      rx_left--;
    end else begin
      m_tready <= 1;
      if ($urandom_range(0, 3) == 0) rx_left = gap_len();
    end
  end

  task automatic check_field(string name, logic [63:0] exp, logic [63:0] act);
    if (exp !== act) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %h, got %h", name, exp, act);
    end
  endtask

  always @(posedge clk) begin
    result_t got, exp;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[$bits(result_t)-1:0];
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", got);
      end else begin
        exp = expected_results.pop_front();
        check_field("r_written", exp.r_written, got.r_written);
        check_field("r_value", exp.r_value, got.r_value);
        check_field("w_written", exp.w_written, got.w_written);
        check_field("w_value", exp.w_value, got.w_value);
        check_field("compare_flag", exp.compare_flag, got.compare_flag);
        check_field("branch_taken", exp.branch_taken, got.branch_taken);
        check_field("branch_offset", exp.branch_offset, got.branch_offset);
        check_field("exit_taken", exp.exit_taken, got.exit_taken);
        check_field("exit_value", exp.exit_value, got.exit_value);
        check_field("bad_dest", exp.bad_dest, got.bad_dest);
      end
    end
  end

  initial begin
    rst = 1; s_tvalid = 0; s_tdata = '0; m_tready = 0;
    cfg_we = 0; cfg_index = CFG_ENV; cfg_data = '0;
    hold_rx = 0; no_idle = 0; rx_left = 0; mismatches = 0;
    env_ptr = 0; frame_ptr = 0; flag = 0;
    for (int k = 0; k < N_GPR; k++) gpr[k] = 0;
    repeat (4) @(posedge clk);
    @(negedge clk) rst = 0;

    test_directed();
    write_cfg(CFG_ENV, '1);
    write_cfg(CFG_FRAME, MIN64);
    test_directed();
    test_opcode_sweep();
    test_random(500);
    write_cfg(CFG_ENV, {$urandom, $urandom});
    write_cfg(CFG_FRAME, {$urandom, $urandom});
    test_backpressure();
    test_random(500);
    write_cfg(CFG_ENV, 64'h7fff_ffff_ffff_ffff);
    write_cfg(CFG_FRAME, 0);
    test_random(400);

    if (mismatches == 0 && expected_results.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: sim.f
src/bae_pkg.sv
src/bae_mul.sv
src/bae_div.sv
src/bytecode_alu_execute_unit.sv
tb/bytecode_alu_execute_unit_tb.sv
